[design/tnc_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tnc_pkg
// Shared constants, codes and types of the thumbnail cell LRU cache.
// ----------------------------------------------------------------------------
package tnc_pkg;

   localparam int CELL_COUNT  = 256;
   localparam int GRID_WIDTH  = 16;

   localparam int CELL_IDX_W  = $clog2(CELL_COUNT);
   localparam int FILL_W      = $clog2(CELL_COUNT + 1);
   localparam int COL_W       = $clog2(GRID_WIDTH);

   localparam int OPCODE_W    = 1;
   localparam int OBJ_ID_W    = 32;
   localparam int STAMP_W     = 32;
   localparam int CFG_W       = 10;
   localparam int OUT_IDX_W   = 8;
   localparam int PIX_W       = 13;
   localparam int PROD_W      = CELL_IDX_W + CFG_W + PIX_W;

   localparam logic [CFG_W-1:0]   CELL_SIZE_RESET = CFG_W'(64);
   localparam logic [STAMP_W-1:0] STAMP_MAX       = '1;

   typedef enum logic [OPCODE_W-1:0] {
      OP_LOOKUP = 1'b0,
      OP_TICK   = 1'b1
   } opcode_type;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_SCAN   = 3'b010,
      ST_UPDATE = 3'b100
   } state_type;

   typedef struct packed {
      logic                rotated;
      logic [STAMP_W-1:0]  stamp;
      logic [OBJ_ID_W-1:0] tag;
   } cell_word_type;

   localparam int CELL_WORD_W = $bits(cell_word_type);

   typedef struct packed {
      logic                  wr_en;
      logic [CELL_IDX_W-1:0] wr_addr;
      cell_word_type         wr_data;
      logic                  rd_en;
      logic [CELL_IDX_W-1:0] rd_addr;
   } ram_req_type;

   typedef struct packed {
      logic                  hit;
      logic [CELL_IDX_W-1:0] cell_idx;
      logic                  redraw;
   } result_type;

endpackage
`default_nettype wire

[design/tnc_req_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tnc_req_if
// Request channel: lookup or frame tick transactions.
// ----------------------------------------------------------------------------
interface tnc_req_if import tnc_pkg::*;;
   logic                valid;
   logic                ready;
   logic [OPCODE_W-1:0] opcode;
   logic [OBJ_ID_W-1:0] object_id;
   logic                animate;

   modport source (output valid, output opcode, output object_id, output animate,
                   input ready);
   modport sink   (input valid, input opcode, input object_id, input animate,
                   output ready);
endinterface
`default_nettype wire

[design/tnc_rsp_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tnc_rsp_if
// Response channel: one transaction per lookup.
// ----------------------------------------------------------------------------
interface tnc_rsp_if import tnc_pkg::*;;
   logic                 valid;
   logic                 ready;
   logic                 hit;
   logic [OUT_IDX_W-1:0] cell_index;
   logic [PIX_W-1:0]     pixel_x;
   logic [PIX_W-1:0]     pixel_y;
   logic                 redraw;

   modport source (output valid, output hit, output cell_index, output pixel_x,
                   output pixel_y, output redraw, input ready);
   modport sink   (input valid, input hit, input cell_index, input pixel_x,
                   input pixel_y, input redraw, output ready);
endinterface
`default_nettype wire

[design/tnc_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tnc_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module tnc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule
`default_nettype wire

[design/tnc_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tnc_ctrl
// Lookup sequencer: scans the cell memory one entry per cycle, picks the hit,
// free or oldest cell, writes it back and hands the result on.
// ----------------------------------------------------------------------------
module tnc_ctrl import tnc_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   tnc_req_if.sink            req,
   output ram_req_type        ram_req,
   input  wire cell_word_type ram_rd_data,
   input  wire logic          out_free,
   output logic               res_valid,
   output result_type         res
);

   state_type             state_ff, state_in;
   logic [FILL_W-1:0]     fill_ff, fill_in;
   logic [STAMP_W-1:0]    frame_ff, frame_in;
   logic [FILL_W-1:0]     rd_idx_ff, rd_idx_in;
   logic                  cmp_vld_ff, cmp_vld_in;
   logic [CELL_IDX_W-1:0] cmp_idx_ff, cmp_idx_in;
   logic                  have_old_ff, have_old_in;
   logic [STAMP_W-1:0]    old_stamp_ff, old_stamp_in;
   logic [CELL_IDX_W-1:0] old_idx_ff, old_idx_in;
   logic [OBJ_ID_W-1:0]   id_ff, id_in;
   logic                  animate_ff, animate_in;
   logic                  hit_ff, hit_in;
   logic                  rot_ff, rot_in;
   logic [CELL_IDX_W-1:0] chosen_ff, chosen_in;
   logic                  accept;
   logic                  not_full;

   assign req.ready = (state_ff == ST_IDLE);
   assign accept    = req.valid && req.ready;
   assign not_full  = (fill_ff < FILL_W'(CELL_COUNT));

   always_comb begin
      state_in     = state_ff;
      fill_in      = fill_ff;
      frame_in     = frame_ff;
      rd_idx_in    = rd_idx_ff;
      cmp_vld_in   = cmp_vld_ff;
      cmp_idx_in   = cmp_idx_ff;
      have_old_in  = have_old_ff;
      old_stamp_in = old_stamp_ff;
      old_idx_in   = old_idx_ff;
      id_in        = id_ff;
      animate_in   = animate_ff;
      hit_in       = hit_ff;
      rot_in       = rot_ff;
      chosen_in    = chosen_ff;
      ram_req      = '0;
      res_valid    = 1'b0;
      res.hit      = hit_ff;
      res.cell_idx = chosen_ff;
      res.redraw   = hit_ff ? (animate_ff || rot_ff) : 1'b1;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req.opcode == OP_TICK) begin
                  if (frame_ff != STAMP_MAX) begin
                     frame_in = frame_ff + STAMP_W'(1);
                  end
               end else begin
                  id_in       = req.object_id;
                  animate_in  = req.animate;
                  rd_idx_in   = '0;
                  cmp_vld_in  = 1'b0;
                  have_old_in = 1'b0;
                  state_in    = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (cmp_vld_ff && (ram_rd_data.tag == id_ff)) begin
               hit_in     = 1'b1;
               rot_in     = ram_rd_data.rotated;
               chosen_in  = cmp_idx_ff;
               cmp_vld_in = 1'b0;
               state_in   = ST_UPDATE;
            end else if (!cmp_vld_ff && (rd_idx_ff == fill_ff)) begin
               hit_in    = 1'b0;
               rot_in    = 1'b0;
               chosen_in = not_full ? fill_ff[CELL_IDX_W-1:0] : old_idx_ff;
               state_in  = ST_UPDATE;
            end else begin
               if (cmp_vld_ff && (!have_old_ff || (ram_rd_data.stamp < old_stamp_ff))) begin
                  have_old_in  = 1'b1;
                  old_stamp_in = ram_rd_data.stamp;
                  old_idx_in   = cmp_idx_ff;
               end
               if (rd_idx_ff < fill_ff) begin
                  ram_req.rd_en   = 1'b1;
                  ram_req.rd_addr = rd_idx_ff[CELL_IDX_W-1:0];
                  cmp_vld_in      = 1'b1;
                  cmp_idx_in      = rd_idx_ff[CELL_IDX_W-1:0];
                  rd_idx_in       = rd_idx_ff + FILL_W'(1);
               end else begin
                  cmp_vld_in = 1'b0;
               end
            end
         end
         ST_UPDATE: begin
            if (out_free) begin
               ram_req.wr_en           = 1'b1;
               ram_req.wr_addr         = chosen_ff;
               ram_req.wr_data.tag     = id_ff;
               ram_req.wr_data.stamp   = frame_ff;
               ram_req.wr_data.rotated = hit_ff && animate_ff;
               res_valid               = 1'b1;
               if (!hit_ff && not_full) begin
                  fill_in = fill_ff + FILL_W'(1);
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         fill_ff    <= '0;
         frame_ff   <= '0;
         cmp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         fill_ff    <= fill_in;
         frame_ff   <= frame_in;
         cmp_vld_ff <= cmp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff    <= rd_idx_in;
      cmp_idx_ff   <= cmp_idx_in;
      have_old_ff  <= have_old_in;
      old_stamp_ff <= old_stamp_in;
      old_idx_ff   <= old_idx_in;
      id_ff        <= id_in;
      animate_ff   <= animate_in;
      hit_ff       <= hit_in;
      rot_ff       <= rot_in;
      chosen_ff    <= chosen_in;
   end

   a_fill_bounded: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_W'(CELL_COUNT))
      else $error("fill count beyond cell count");

   a_no_rw_overlap: assert property (@(posedge clock) disable iff (reset)
      !(ram_req.wr_en && ram_req.rd_en))
      else $error("cell memory read and write in one cycle");

   a_result_room: assert property (@(posedge clock) disable iff (reset)
      res_valid |-> (out_free && (state_ff == ST_UPDATE)))
      else $error("result issued without room in output stage");

   a_lookup_starts_scan: assert property (@(posedge clock) disable iff (reset)
      (accept && (req.opcode == OP_LOOKUP)) |=> (state_ff == ST_SCAN))
      else $error("lookup transaction did not start a scan");

   a_fill_on_miss_only: assert property (@(posedge clock) disable iff (reset)
      (fill_ff != $past(fill_ff)) |-> $past(res_valid && !hit_ff))
      else $error("fill count moved without a miss");

endmodule
`default_nettype wire

[design/tnc_out.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tnc_out
// Response register: forms the pixel position of the cell and holds the
// transaction until the receiver takes it.
// ----------------------------------------------------------------------------
module tnc_out import tnc_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic [CFG_W-1:0] cell_size,
   input  wire logic             res_valid,
   input  wire result_type       res,
   output logic                  out_free,
   tnc_rsp_if.source             rsp
);

   logic              valid_ff, valid_in;
   logic [COL_W-1:0]  col;
   logic [CELL_IDX_W-1:0] row;
   logic [PROD_W-1:0] x_prod;
   logic [PROD_W-1:0] y_prod;

   assign col      = COL_W'(res.cell_idx % GRID_WIDTH);
   assign row      = CELL_IDX_W'(res.cell_idx / GRID_WIDTH);
   assign x_prod   = PROD_W'(col) * PROD_W'(cell_size);
   assign y_prod   = PROD_W'(row) * PROD_W'(cell_size);
   assign out_free = !valid_ff || rsp.ready;
   assign rsp.valid = valid_ff;

   always_comb begin
      priority if (res_valid) begin
         valid_in = 1'b1;
      end else if (rsp.ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid) begin
         rsp.hit        <= res.hit;
         rsp.cell_index <= OUT_IDX_W'(res.cell_idx);
         rsp.pixel_x    <= x_prod[PIX_W-1:0];
         rsp.pixel_y    <= y_prod[PIX_W-1:0];
         rsp.redraw     <= res.redraw;
      end
   end

endmodule
`default_nettype wire

[design/thumbnail_cell_lru_cache.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// thumbnail_cell_lru_cache
// Fully associative atlas cell cache keyed by object id, LRU by frame stamp.
//
// Request channel (req_if): a lookup transaction carries an object id and
// the animate flag; a tick transaction advances the frame stamp and returns
// nothing. Response channel (rsp_if): one transaction per lookup with hit,
// cell index, pixel position in the grid and the redraw flag.
// csr_write_enable/csr_write_data set the cell size in pixels (reset 64).
// A lookup scans the filled cells of the cell memory one per cycle, as the
// cell memory has a single read port. A new request is taken only once
// the previous lookup has been written back.
// Reset empties the cache at once through its fill count and clears the
// frame stamp. A stalled response is held in the output register; the next
// lookup runs its scan meanwhile and waits before write-back until the
// register is free.
// ----------------------------------------------------------------------------
module thumbnail_cell_lru_cache import tnc_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             csr_write_enable,
   input  wire logic [CFG_W-1:0] csr_write_data,
   tnc_req_if.sink               req_if,
   tnc_rsp_if.source             rsp_if
);

   logic [CFG_W-1:0] cell_size_ff, cell_size_in;
   ram_req_type      ram_req;
   cell_word_type    ram_rd_data;
   logic             out_free;
   logic             res_valid;
   result_type       res;

   assign cell_size_in = csr_write_enable ? csr_write_data : cell_size_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_size_ff <= CELL_SIZE_RESET;
      end else begin
         cell_size_ff <= cell_size_in;
      end
   end

   tnc_ram #(
      .WIDTH (CELL_WORD_W),
      .DEPTH (CELL_COUNT)
   ) u_cell_ram (
      .clock   (clock),
      .wr_en   (ram_req.wr_en),
      .wr_addr (ram_req.wr_addr),
      .wr_data (ram_req.wr_data),
      .rd_en   (ram_req.rd_en),
      .rd_addr (ram_req.rd_addr),
      .rd_data (ram_rd_data)
   );

   tnc_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req         (req_if),
      .ram_req     (ram_req),
      .ram_rd_data (ram_rd_data),
      .out_free    (out_free),
      .res_valid   (res_valid),
      .res         (res)
   );

   tnc_out u_out (
      .clock     (clock),
      .reset     (reset),
      .cell_size (cell_size_ff),
      .res_valid (res_valid),
      .res       (res),
      .out_free  (out_free),
      .rsp       (rsp_if)
   );

endmodule
`default_nettype wire
